// ----- rtl/vmrab_pkg.sv -----
// Package for the register/ALU/branch core: opcode groups, ALU sub-ops,
// reset constants and the structs passed between the core's modules.
// No dependencies.
`default_nettype none

package vmrab_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 8;
    localparam int WORD_W  = 16;
    localparam int REG_CNT = 16;
    localparam int REG_AW  = 4;

    localparam logic [ADDR_W-1:0] PC_RESET  = 12'h200;
    localparam logic [ADDR_W-1:0] PC_STEP   = 12'd2;
    localparam logic [REG_AW-1:0] VF_IDX    = 4'hF;
    localparam logic [WORD_W-1:0] OP_RETURN = 16'h00EE;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS     = 4'h0;
    localparam logic [3:0] GRP_JUMP    = 4'h1;
    localparam logic [3:0] GRP_CALL    = 4'h2;
    localparam logic [3:0] GRP_SE_IMM  = 4'h3;
    localparam logic [3:0] GRP_SNE_IMM = 4'h4;
    localparam logic [3:0] GRP_SE_REG  = 4'h5;
    localparam logic [3:0] GRP_LD_IMM  = 4'h6;
    localparam logic [3:0] GRP_ADD_IMM = 4'h7;
    localparam logic [3:0] GRP_ALU     = 4'h8;
    localparam logic [3:0] GRP_SNE_REG = 4'h9;
    localparam logic [3:0] GRP_LD_I    = 4'hA;

    // ALU sub-ops (low nibble of group 8)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    typedef struct packed {
        logic              vx_we;
        logic [REG_AW-1:0] waddr;
        logic [DATA_W-1:0] vx_data;
        logic              vf_we;
        logic [DATA_W-1:0] vf_data;
    } rf_write_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [ADDR_W-1:0] data;
    } stack_op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] index;
        logic [DATA_W-1:0] dest;
        logic [DATA_W-1:0] flag;
        logic              unsupported;
        rf_write_t         rf;
        stack_op_t         stk;
    } exec_result_t;

endpackage

`default_nettype wire

// ----- rtl/vmrab_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vmrab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/vmrab_regfile.sv -----
// General register file V0..VF: V0..VE in two RAM copies (x and y ports),
// VF in its own flop. Valid bits give the zero reset value.
// Depends on vmrab_pkg and vmrab_ram.
`default_nettype none

module vmrab_regfile (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [vmrab_pkg::REG_AW-1:0] raddr_x,
    input  wire logic [vmrab_pkg::REG_AW-1:0] raddr_y,
    input  wire vmrab_pkg::rf_write_t         wr,
    output logic      [vmrab_pkg::DATA_W-1:0] vx,
    output logic      [vmrab_pkg::DATA_W-1:0] vy,
    output logic      [vmrab_pkg::DATA_W-1:0] vf
);

    logic [vmrab_pkg::REG_CNT-1:0] vld_reg;
    logic [vmrab_pkg::DATA_W-1:0]  vf_reg;
    logic [vmrab_pkg::REG_AW-1:0]  rx_reg;
    logic [vmrab_pkg::REG_AW-1:0]  ry_reg;
    logic                          x_vld_reg;
    logic                          y_vld_reg;
    logic                          x_fwd_reg;
    logic                          y_fwd_reg;
    logic [vmrab_pkg::DATA_W-1:0]  fwd_data_reg;
    logic [vmrab_pkg::DATA_W-1:0]  ram_x;
    logic [vmrab_pkg::DATA_W-1:0]  ram_y;
    logic                          ram_we;

    assign ram_we = wr.vx_we && (wr.waddr != vmrab_pkg::VF_IDX);

    vmrab_ram #(
        .WIDTH (vmrab_pkg::DATA_W),
        .DEPTH (vmrab_pkg::REG_CNT)
    ) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr.waddr),
        .wdata (wr.vx_data),
        .raddr (raddr_x),
        .rdata (ram_x)
    );

    vmrab_ram #(
        .WIDTH (vmrab_pkg::DATA_W),
        .DEPTH (vmrab_pkg::REG_CNT)
    ) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr.waddr),
        .wdata (wr.vx_data),
        .raddr (raddr_y),
        .rdata (ram_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vf_reg  <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                vld_reg[wr.waddr] <= 1'b1;
            end
            if (wr.vf_we)
            begin
                vf_reg <= wr.vf_data;
            end
        end
    end

    // RAM reads old data on a same-cycle write, so forward the write
    always_ff @(posedge clk)
    begin
        rx_reg       <= raddr_x;
        ry_reg       <= raddr_y;
        x_vld_reg    <= vld_reg[raddr_x];
        y_vld_reg    <= vld_reg[raddr_y];
        x_fwd_reg    <= ram_we && (wr.waddr == raddr_x);
        y_fwd_reg    <= ram_we && (wr.waddr == raddr_y);
        fwd_data_reg <= wr.vx_data;
    end

    always_comb
    begin
        if (rx_reg == vmrab_pkg::VF_IDX)
            vx = vf_reg;
        else if (x_fwd_reg)
            vx = fwd_data_reg;
        else if (x_vld_reg)
            vx = ram_x;
        else
            vx = '0;

        if (ry_reg == vmrab_pkg::VF_IDX)
            vy = vf_reg;
        else if (y_fwd_reg)
            vy = fwd_data_reg;
        else if (y_vld_reg)
            vy = ram_y;
        else
            vy = '0;
    end

    assign vf = vf_reg;

endmodule

`default_nettype wire

// ----- rtl/vmrab_stack.sv -----
// Return stack: RAM with per-entry valid bits, a wrapping pointer and a
// top-of-stack read that is kept ready every cycle.
// Depends on vmrab_pkg and vmrab_ram.
`default_nettype none

module vmrab_stack #(
    parameter int DEPTH = vmrab_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire vmrab_pkg::stack_op_t         op,
    output logic      [vmrab_pkg::ADDR_W-1:0] top
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0]                 sp_reg;
    logic [AW-1:0]                 sp_next;
    logic [AW-1:0]                 sp_inc;
    logic [AW-1:0]                 sp_dec;
    logic [AW-1:0]                 rd_addr;
    logic [DEPTH-1:0]              vld_reg;
    logic                          top_vld_reg;
    logic                          byp_reg;
    logic [vmrab_pkg::ADDR_W-1:0]  byp_data_reg;
    logic [vmrab_pkg::ADDR_W-1:0]  ram_rdata;

    always_comb
    begin
        sp_inc = (sp_reg == LAST) ? '0 : sp_reg + 1'b1;
        sp_dec = (sp_reg == '0) ? LAST : sp_reg - 1'b1;
        if (op.push)
            sp_next = sp_inc;
        else if (op.pop)
            sp_next = sp_dec;
        else
            sp_next = sp_reg;
        // entry a return would read after this cycle
        rd_addr = (sp_next == '0) ? LAST : sp_next - 1'b1;
    end

    vmrab_ram #(
        .WIDTH (vmrab_pkg::ADDR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (op.push),
        .waddr (sp_reg),
        .wdata (op.data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            vld_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
            if (op.push)
            begin
                vld_reg[sp_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_vld_reg  <= vld_reg[rd_addr];
        byp_reg      <= op.push && (sp_reg == rd_addr);
        byp_data_reg <= op.data;
    end

    always_comb
    begin
        if (byp_reg)
            top = byp_data_reg;
        else if (top_vld_reg)
            top = ram_rdata;
        else
            top = '0;
    end

endmodule

`default_nettype wire

// ----- rtl/vmrab_exec.sv -----
// Execute logic: decodes one instruction word against the current state
// and produces the new counter, I, register writes and stack operation.
// Depends on vmrab_pkg.
`default_nettype none

module vmrab_exec (
    input  wire logic [vmrab_pkg::WORD_W-1:0] word,
    input  wire logic [vmrab_pkg::DATA_W-1:0] vx,
    input  wire logic [vmrab_pkg::DATA_W-1:0] vy,
    input  wire logic [vmrab_pkg::DATA_W-1:0] vf,
    input  wire logic [vmrab_pkg::ADDR_W-1:0] pc,
    input  wire logic [vmrab_pkg::ADDR_W-1:0] index,
    input  wire logic [vmrab_pkg::ADDR_W-1:0] stack_top,
    output vmrab_pkg::exec_result_t           res
);

    logic [3:0]                   grp;
    logic [vmrab_pkg::REG_AW-1:0] x;
    logic [3:0]                   n;
    logic [vmrab_pkg::DATA_W-1:0] kk;
    logic [vmrab_pkg::ADDR_W-1:0] nnn;
    logic [vmrab_pkg::ADDR_W-1:0] pc_adv;
    logic [vmrab_pkg::ADDR_W-1:0] pc_skip;
    logic [vmrab_pkg::DATA_W:0]   sum;
    logic [vmrab_pkg::DATA_W-1:0] alu_res;
    logic                         alu_flg;
    logic                         wr;
    logic                         alu;
    logic [vmrab_pkg::DATA_W-1:0] wdata;
    logic [vmrab_pkg::DATA_W-1:0] vf_new;

    assign grp     = word[15:12];
    assign x       = word[11:8];
    assign n       = word[3:0];
    assign kk      = word[7:0];
    assign nnn     = word[11:0];
    assign pc_adv  = pc + vmrab_pkg::PC_STEP;
    assign pc_skip = pc_adv + vmrab_pkg::PC_STEP;
    assign sum     = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        res.pc          = pc_adv;
        res.index       = index;
        res.unsupported = 1'b0;
        res.stk.push    = 1'b0;
        res.stk.pop     = 1'b0;
        res.stk.data    = pc_adv;
        wr              = 1'b0;
        alu             = 1'b0;
        wdata           = vx;
        alu_res         = vx;
        alu_flg         = 1'b0;

        case (n)
            vmrab_pkg::ALU_MOV:  alu_res = vy;
            vmrab_pkg::ALU_OR:   alu_res = vx | vy;
            vmrab_pkg::ALU_AND:  alu_res = vx & vy;
            vmrab_pkg::ALU_XOR:  alu_res = vx ^ vy;
            vmrab_pkg::ALU_ADD:
            begin
                alu_res = sum[vmrab_pkg::DATA_W-1:0];
                alu_flg = sum[vmrab_pkg::DATA_W];
            end
            vmrab_pkg::ALU_SUB:
            begin
                alu_res = vx - vy;
                alu_flg = (vx >= vy);
            end
            vmrab_pkg::ALU_SHR:
            begin
                alu_res = {1'b0, vx[vmrab_pkg::DATA_W-1:1]};
                alu_flg = vx[0];
            end
            vmrab_pkg::ALU_SUBN:
            begin
                alu_res = vy - vx;
                alu_flg = (vy >= vx);
            end
            vmrab_pkg::ALU_SHL:
            begin
                alu_res = {vx[vmrab_pkg::DATA_W-2:0], 1'b0};
                alu_flg = vx[vmrab_pkg::DATA_W-1];
            end
            default:             alu_res = vx;
        endcase

        case (grp)
            vmrab_pkg::GRP_SYS:
            begin
                if (word == vmrab_pkg::OP_RETURN)
                begin
                    res.stk.pop = 1'b1;
                    res.pc      = stack_top;
                end
            end
            vmrab_pkg::GRP_JUMP:
                res.pc = nnn;
            vmrab_pkg::GRP_CALL:
            begin
                res.stk.push = 1'b1;
                res.pc       = nnn;
            end
            vmrab_pkg::GRP_SE_IMM:
                if (vx == kk) res.pc = pc_skip;
            vmrab_pkg::GRP_SNE_IMM:
                if (vx != kk) res.pc = pc_skip;
            vmrab_pkg::GRP_SE_REG:
                if (vx == vy) res.pc = pc_skip;
            vmrab_pkg::GRP_LD_IMM:
            begin
                wr    = 1'b1;
                wdata = kk;
            end
            vmrab_pkg::GRP_ADD_IMM:
            begin
                wr    = 1'b1;
                wdata = vx + kk;
            end
            vmrab_pkg::GRP_ALU:
            begin
                case (n) inside
                    [vmrab_pkg::ALU_MOV:vmrab_pkg::ALU_XOR]:
                    begin
                        wr    = 1'b1;
                        wdata = alu_res;
                    end
                    [vmrab_pkg::ALU_ADD:vmrab_pkg::ALU_SUBN], vmrab_pkg::ALU_SHL:
                    begin
                        wr    = 1'b1;
                        alu   = 1'b1;
                        wdata = alu_res;
                    end
                    default:
                        wr = 1'b0;
                endcase
            end
            vmrab_pkg::GRP_SNE_REG:
                if (vx != vy) res.pc = pc_skip;
            vmrab_pkg::GRP_LD_I:
                res.index = nnn;
            default:
                res.unsupported = 1'b1;
        endcase

        // flag is written last, so with x = F the flag wins
        res.rf.waddr   = x;
        res.rf.vx_data = wdata;
        res.rf.vx_we   = wr && (x != vmrab_pkg::VF_IDX);
        res.rf.vf_we   = alu || (wr && (x == vmrab_pkg::VF_IDX));
        res.rf.vf_data = alu ? {{(vmrab_pkg::DATA_W-1){1'b0}}, alu_flg} : wdata;

        vf_new   = res.rf.vf_we ? res.rf.vf_data : vf;
        res.flag = vf_new;
        if (x == vmrab_pkg::VF_IDX)
            res.dest = vf_new;
        else if (wr)
            res.dest = wdata;
        else
            res.dest = vx;
    end

endmodule

`default_nettype wire

// ----- rtl/vm_register_alu_branch_core.sv -----
// Top level of the register/ALU/branch core: input register, execute,
// architectural state and result register.
// Depends on vmrab_pkg, vmrab_regfile, vmrab_stack and vmrab_exec.
//
//   channel   direction  handshake           payload
//   in        request    in_valid/in_stall   instruction_word
//   out       result     out_valid/out_stall next_address, index_value,
//                                            dest_value, flag_value, unsupported
//
// One instruction per cycle sustained while the result is not stalled; a
// request passes the input register, then execute into the result register.
// The register file and return stack are RAMs read ahead, with write
// forwarding. Reset sets PC to 0x200, clears I and VF, and clears V0..VE
// and the stack at once through valid bits; no clearing pass.
// A stalled result holds; in_stall rises only while the result register
// is full and stalled.
`default_nettype none

module vm_register_alu_branch_core #(
    parameter int STACK_DEPTH = vmrab_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [vmrab_pkg::WORD_W-1:0] instruction_word,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [vmrab_pkg::ADDR_W-1:0] next_address,
    output logic      [vmrab_pkg::ADDR_W-1:0] index_value,
    output logic      [vmrab_pkg::DATA_W-1:0] dest_value,
    output logic      [vmrab_pkg::DATA_W-1:0] flag_value,
    output logic                              unsupported
);

    logic                          in_vld_reg;
    logic [vmrab_pkg::WORD_W-1:0]  word_reg;
    logic                          out_vld_reg;
    logic                          out_vld_next;
    logic [vmrab_pkg::ADDR_W-1:0]  pc_reg;
    logic [vmrab_pkg::ADDR_W-1:0]  index_reg;
    logic [vmrab_pkg::ADDR_W-1:0]  res_pc_reg;
    logic [vmrab_pkg::ADDR_W-1:0]  res_index_reg;
    logic [vmrab_pkg::DATA_W-1:0]  res_dest_reg;
    logic [vmrab_pkg::DATA_W-1:0]  res_flag_reg;
    logic                          res_unsup_reg;
    logic                          fire;
    logic                          in_accept;
    logic [vmrab_pkg::REG_AW-1:0]  rd_x;
    logic [vmrab_pkg::REG_AW-1:0]  rd_y;
    logic [vmrab_pkg::DATA_W-1:0]  vx;
    logic [vmrab_pkg::DATA_W-1:0]  vy;
    logic [vmrab_pkg::DATA_W-1:0]  vf;
    logic [vmrab_pkg::ADDR_W-1:0]  stack_top;
    vmrab_pkg::exec_result_t       ex;
    vmrab_pkg::rf_write_t          rf_wr;
    vmrab_pkg::stack_op_t          stk_op;

    assign fire      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    // operand reads follow the word that will sit in the input register
    assign rd_x = in_accept ? instruction_word[11:8] : word_reg[11:8];
    assign rd_y = in_accept ? instruction_word[7:4]  : word_reg[7:4];

    always_comb
    begin
        rf_wr          = ex.rf;
        rf_wr.vx_we    = ex.rf.vx_we && fire;
        rf_wr.vf_we    = ex.rf.vf_we && fire;
        stk_op         = ex.stk;
        stk_op.push    = ex.stk.push && fire;
        stk_op.pop     = ex.stk.pop && fire;
        out_vld_next   = fire || (out_vld_reg && out_stall);
    end

    vmrab_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .raddr_x (rd_x),
        .raddr_y (rd_y),
        .wr      (rf_wr),
        .vx      (vx),
        .vy      (vy),
        .vf      (vf)
    );

    vmrab_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stk_op),
        .top   (stack_top)
    );

    vmrab_exec u_exec (
        .word      (word_reg),
        .vx        (vx),
        .vy        (vy),
        .vf        (vf),
        .pc        (pc_reg),
        .index     (index_reg),
        .stack_top (stack_top),
        .res       (ex)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= vmrab_pkg::PC_RESET;
            index_reg   <= '0;
        end
        else
        begin
            if (in_accept)
                in_vld_reg <= 1'b1;
            else if (fire)
                in_vld_reg <= 1'b0;
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                pc_reg    <= ex.pc;
                index_reg <= ex.index;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            word_reg <= instruction_word;
        end
        if (fire)
        begin
            res_pc_reg    <= ex.pc;
            res_index_reg <= ex.index;
            res_dest_reg  <= ex.dest;
            res_flag_reg  <= ex.flag;
            res_unsup_reg <= ex.unsupported;
        end
    end

    assign out_valid    = out_vld_reg;
    assign next_address = res_pc_reg;
    assign index_value  = res_index_reg;
    assign dest_value   = res_dest_reg;
    assign flag_value   = res_flag_reg;
    assign unsupported  = res_unsup_reg;

endmodule

`default_nettype wire

// ----- rtl/vmrab_checker.sv -----
// Port-level checker for vm_register_alu_branch_core, bound to the top.
// Depends on vmrab_pkg; tracks the last delivered result.
`default_nettype none

module vmrab_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [vmrab_pkg::ADDR_W-1:0] next_address,
    input wire logic [vmrab_pkg::ADDR_W-1:0] index_value,
    input wire logic [vmrab_pkg::DATA_W-1:0] dest_value,
    input wire logic [vmrab_pkg::DATA_W-1:0] flag_value,
    input wire logic                         unsupported
);

    logic                         out_take;
    logic                         seen_reg;
    logic [vmrab_pkg::ADDR_W-1:0] last_pc_reg;
    logic [vmrab_pkg::ADDR_W-1:0] last_idx_reg;
    logic [vmrab_pkg::DATA_W-1:0] last_vf_reg;
    logic                         in_take;

    assign out_take = out_valid && !out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_pc_reg  <= vmrab_pkg::PC_RESET;
            last_idx_reg <= '0;
            last_vf_reg  <= '0;
        end
        else if (out_take)
        begin
            seen_reg     <= 1'b1;
            last_pc_reg  <= next_address;
            last_idx_reg <= index_value;
            last_vf_reg  <= flag_value;
        end
    end

    // input side only backs up behind a stalled full result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(next_address)
            && $stable(dest_value) && $stable(flag_value)))
        else $error("stalled result changed");

    // unsupported words are no-ops: only the counter moves, by 2
    a_nop_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && unsupported) |->
            (next_address == last_pc_reg + vmrab_pkg::PC_STEP)
            && (index_value == last_idx_reg) && (flag_value == last_vf_reg))
        else $error("unsupported word changed state");

    a_first_nop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !seen_reg && unsupported) |->
            (index_value == '0) && (flag_value == '0) && (dest_value == '0))
        else $error("register state not cleared by reset");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> ##1 (out_valid || $past(out_valid, 1)))
        else $error("accepted request produced no result");

endmodule

bind vm_register_alu_branch_core vmrab_checker u_checker (.*);

`default_nettype wire
